/* sv/rmge_pkg.sv */
// Shared types and constants for the reachable maximum graph engine.
package rmge_pkg;

  localparam int NODES_DEF = 512;
  localparam int MEMBER_W  = 9;
  localparam int TIME_W    = 16;
  localparam int ACTION_W  = 2;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_SWAP  = 2'd2,
    ACT_QUERY = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ADR_CNT = 2'd0,
    ADR_A   = 2'd1,
    ADR_B   = 2'd2
  } adr_sel_t;

  typedef enum logic [2:0] {
    WD_ZERO    = 3'd0,
    WD_ADD     = 3'd1,
    WD_RDATA   = 3'd2,
    WD_TMP     = 3'd3,
    WD_COLSWAP = 3'd4
  } wd_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_WR,
    ST_SW_RB,
    ST_SW_WA,
    ST_SW_WB,
    ST_SW_CRD,
    ST_SW_CWR,
    ST_Q_RD,
    ST_Q_UP,
    ST_V_RD,
    ST_V_UP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     mat_we;
    adr_sel_t mat_wa_sel;
    adr_sel_t mat_ra_sel;
    wd_sel_t  mat_wd_sel;
    logic     tmp_ld;
    logic     val_we;
    logic     q_init;
    logic     r_update;
    logic     chg_clr;
    logic     v_update;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic a_ok;
    logic b_ok;
    logic same;
    logic cnt_last;
    logic changed;
  } stat_t;

endpackage

/* sv/rmge_ram.sv */
// Generic simple dual-port RAM with registered read.
module rmge_ram #(
  parameter int W = 16,
  parameter int D = 512
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/rmge_dp.sv */
// Datapath: boss matrix and value memories, reach vector, running maximum.
module rmge_dp #(
  parameter int NODES = rmge_pkg::NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rmge_pkg::cmd_t                 cmd,
  output rmge_pkg::stat_t                stat,
  input  logic [rmge_pkg::ACTION_W-1:0]  action,
  input  logic [rmge_pkg::MEMBER_W-1:0]  first_member,
  input  logic [rmge_pkg::MEMBER_W-1:0]  second_member,
  input  logic [rmge_pkg::TIME_W-1:0]    time_value,
  output logic [rmge_pkg::TIME_W-1:0]    peak_time,
  output logic                           none_reachable
);

  localparam int AW = $clog2(NODES);

  logic [rmge_pkg::ACTION_W-1:0] act_r;
  logic [rmge_pkg::MEMBER_W-1:0] a_r, b_r;
  logic [rmge_pkg::TIME_W-1:0]   v_r;
  logic [AW-1:0]                 aidx, bidx, cnt;
  logic [AW-1:0]                 mat_raddr, mat_waddr;
  logic [NODES-1:0]              mat_rdata, mat_wdata, tmp, reach, colswap, a_hot;
  logic [rmge_pkg::TIME_W-1:0]   val_rdata, best;
  logic                          found, changed, row_grows;

  assign aidx  = AW'(a_r);
  assign bidx  = AW'(b_r);
  assign a_hot = NODES'(1) << aidx;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action;
      a_r   <= first_member;
      b_r   <= second_member;
      v_r   <= time_value;
    end
    if (cmd.tmp_ld) begin
      tmp <= mat_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + AW'(1);
    end
  end

  always_comb begin
    unique case (cmd.mat_ra_sel)
      rmge_pkg::ADR_A: mat_raddr = aidx;
      rmge_pkg::ADR_B: mat_raddr = bidx;
      default:         mat_raddr = cnt;
    endcase
    unique case (cmd.mat_wa_sel)
      rmge_pkg::ADR_A: mat_waddr = aidx;
      rmge_pkg::ADR_B: mat_waddr = bidx;
      default:         mat_waddr = cnt;
    endcase
  end

  // Swap columns a and b of the row just read.
  always_comb begin
    colswap       = mat_rdata;
    colswap[aidx] = mat_rdata[bidx];
    colswap[bidx] = mat_rdata[aidx];
  end

  always_comb begin
    unique case (cmd.mat_wd_sel)
      rmge_pkg::WD_ADD:     mat_wdata = mat_rdata | a_hot;
      rmge_pkg::WD_RDATA:   mat_wdata = mat_rdata;
      rmge_pkg::WD_TMP:     mat_wdata = tmp;
      rmge_pkg::WD_COLSWAP: mat_wdata = colswap;
      default:              mat_wdata = '0;
    endcase
  end

  rmge_ram #(.W(NODES), .D(NODES)) u_mat (
    .clk   (clk),
    .we    (cmd.mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  rmge_ram #(.W(rmge_pkg::TIME_W), .D(NODES)) u_val (
    .clk   (clk),
    .we    (cmd.val_we),
    .waddr (aidx),
    .wdata (v_r),
    .raddr (cnt),
    .rdata (val_rdata)
  );

  // The row under update adds members not yet in the reach set.
  assign row_grows = cmd.r_update && reach[cnt] && ((mat_rdata & ~reach) != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      changed <= 1'b0;
      found   <= 1'b0;
    end else if (cmd.q_init) begin
      reach   <= a_hot;
      changed <= 1'b0;
      found   <= 1'b0;
      best    <= '0;
    end else begin
      if (cmd.chg_clr) begin
        changed <= 1'b0;
      end else if (row_grows) begin
        changed <= 1'b1;
      end
      if (cmd.r_update && reach[cnt]) begin
        reach <= reach | mat_rdata;
      end
      if (cmd.v_update && reach[cnt] && (cnt != aidx)) begin
        found <= 1'b1;
        if (val_rdata > best) begin
          best <= val_rdata;
        end
      end
    end
  end

  assign peak_time      = best;
  assign none_reachable = ~found;

  assign stat.act      = rmge_pkg::act_t'(act_r);
  assign stat.a_ok     = {23'b0, a_r} < 32'(NODES);
  assign stat.b_ok     = {23'b0, b_r} < 32'(NODES);
  assign stat.same     = (a_r == b_r);
  assign stat.cnt_last = (cnt == AW'(NODES - 1));
  // include the row read this cycle so growth on the last row forces a sweep
  assign stat.changed  = changed | row_grows;

endmodule

/* sv/rmge_ctrl.sv */
// Controller state machine sequencing every action over the datapath.
module rmge_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rmge_pkg::stat_t stat,
  output rmge_pkg::cmd_t  cmd,
  output logic            busy,
  output logic            done
);

  rmge_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmge_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      rmge_pkg::ST_CLEAR: begin
        cmd.mat_we     = 1'b1;
        cmd.mat_wd_sel = rmge_pkg::WD_ZERO;
        cmd.cnt_inc    = 1'b1;
        if (stat.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = rmge_pkg::ST_IDLE;
        end
      end
      rmge_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = rmge_pkg::ST_DISPATCH;
        end
      end
      rmge_pkg::ST_DISPATCH: begin
        unique case (stat.act)
          rmge_pkg::ACT_LOAD: begin
            cmd.val_we = stat.a_ok;
            state_next = rmge_pkg::ST_IDLE;
          end
          rmge_pkg::ACT_ADD: begin
            cmd.mat_ra_sel = rmge_pkg::ADR_B;
            state_next = (stat.a_ok && stat.b_ok) ? rmge_pkg::ST_ADD_WR : rmge_pkg::ST_IDLE;
          end
          rmge_pkg::ACT_SWAP: begin
            cmd.mat_ra_sel = rmge_pkg::ADR_A;
            state_next = (stat.a_ok && stat.b_ok && !stat.same) ?
                         rmge_pkg::ST_SW_RB : rmge_pkg::ST_IDLE;
          end
          default: begin
            cmd.q_init  = 1'b1;
            cmd.cnt_clr = 1'b1;
            state_next  = stat.a_ok ? rmge_pkg::ST_Q_RD : rmge_pkg::ST_DONE;
          end
        endcase
      end
      rmge_pkg::ST_ADD_WR: begin
        cmd.mat_we     = 1'b1;
        cmd.mat_wa_sel = rmge_pkg::ADR_B;
        cmd.mat_wd_sel = rmge_pkg::WD_ADD;
        state_next     = rmge_pkg::ST_IDLE;
      end
      rmge_pkg::ST_SW_RB: begin
        cmd.tmp_ld     = 1'b1;
        cmd.mat_ra_sel = rmge_pkg::ADR_B;
        state_next     = rmge_pkg::ST_SW_WA;
      end
      rmge_pkg::ST_SW_WA: begin
        cmd.mat_we     = 1'b1;
        cmd.mat_wa_sel = rmge_pkg::ADR_A;
        cmd.mat_wd_sel = rmge_pkg::WD_RDATA;
        state_next     = rmge_pkg::ST_SW_WB;
      end
      rmge_pkg::ST_SW_WB: begin
        cmd.mat_we     = 1'b1;
        cmd.mat_wa_sel = rmge_pkg::ADR_B;
        cmd.mat_wd_sel = rmge_pkg::WD_TMP;
        cmd.cnt_clr    = 1'b1;
        state_next     = rmge_pkg::ST_SW_CRD;
      end
      rmge_pkg::ST_SW_CRD: begin
        state_next = rmge_pkg::ST_SW_CWR;
      end
      rmge_pkg::ST_SW_CWR: begin
        cmd.mat_we     = 1'b1;
        cmd.mat_wd_sel = rmge_pkg::WD_COLSWAP;
        if (stat.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = rmge_pkg::ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = rmge_pkg::ST_SW_CRD;
        end
      end
      rmge_pkg::ST_Q_RD: begin
        state_next = rmge_pkg::ST_Q_UP;
      end
      rmge_pkg::ST_Q_UP: begin
        cmd.r_update = 1'b1;
        if (stat.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          cmd.chg_clr = 1'b1;
          // repeat the sweep while it still grows the reach set
          state_next  = stat.changed ? rmge_pkg::ST_Q_RD : rmge_pkg::ST_V_RD;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = rmge_pkg::ST_Q_RD;
        end
      end
      rmge_pkg::ST_V_RD: begin
        state_next = rmge_pkg::ST_V_UP;
      end
      rmge_pkg::ST_V_UP: begin
        cmd.v_update = 1'b1;
        if (stat.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_next  = rmge_pkg::ST_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_next  = rmge_pkg::ST_V_RD;
        end
      end
      default: begin
        done       = 1'b1;
        state_next = rmge_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/reachable_max_graph_engine.sv */
// Top level of the reachable maximum graph engine.
//
// Keeps a boss relation over NODES members as a NODES x NODES bit matrix in
// a row-wide RAM, plus one 16-bit value per member. A word is taken when start
// is high and busy is low; action picks load (0), add edge (1), swap (2) or
// query (3). Only a query gives a result word: done is high for exactly one
// cycle with peak_time and none_reachable, and the receiver cannot stall it, so
// sample it on that cycle. A query repeats matrix sweeps until the reach set
// stops growing (at least 1 sweep, at most the longest boss chain plus 1);
// a query with an out-of-range start skips the sweeps. Each sweep reads one
// matrix row at a time through the single read port, and the final pass reads
// every member value the same way. After reset a clearing pass zeroes the
// matrix, with busy high. Member values are undefined until loaded; load every
// member a query can reach.
module reachable_max_graph_engine #(
  parameter int NODES = rmge_pkg::NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rmge_pkg::ACTION_W-1:0] action,
  input  logic [rmge_pkg::MEMBER_W-1:0] first_member,
  input  logic [rmge_pkg::MEMBER_W-1:0] second_member,
  input  logic [rmge_pkg::TIME_W-1:0]   time_value,
  output logic                          done,
  output logic [rmge_pkg::TIME_W-1:0]   peak_time,
  output logic                          none_reachable
);

  rmge_pkg::cmd_t  cmd;
  rmge_pkg::stat_t stat;

  // sequence actions; hold busy until the action finishes
  rmge_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // memories, reach vector and running maximum
  rmge_dp #(.NODES(NODES)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .action         (action),
    .first_member   (first_member),
    .second_member  (second_member),
    .time_value     (time_value),
    .peak_time      (peak_time),
    .none_reachable (none_reachable)
  );

endmodule
